// File: hw/rtl/utf8v_pkg.sv
// utf8v_pkg: shared types, status codes and lead byte decode for the utf-8 validator
// no dependencies; used by utf8v_step, the validator top, its checker and testbench
`default_nettype none

package utf8v_pkg;

    // output position width, fixed by the result fields
    localparam int POS_OUT_BITS  = 32;
    localparam int POSITION_BITS_DEFAULT = 32;

    typedef logic [2:0] t_status;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_VALID     = 3'd1;
    localparam t_status ST_BAD_START = 3'd2;
    localparam t_status ST_BAD_CONT  = 3'd3;
    localparam t_status ST_UNEXP_END = 3'd4;

    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF4;
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_TWO  = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR = 3'd4;

    typedef struct packed {
        t_status                  status;
        logic [POS_OUT_BITS-1:0]  error_start;
        logic [POS_OUT_BITS-1:0]  error_stop;
        logic [7:0]               error_value;
        logic                     stream_done;
    } t_result;

    // sequence length opened by a lead byte, zero if not a legal lead
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        case (b) inside
            [LEAD2_LO:LEAD2_HI]: len = LEN_TWO;
            [LEAD3_LO:LEAD3_HI]: len = LEN_THREE;
            [LEAD4_LO:LEAD4_HI]: len = LEN_FOUR;
            default:             len = LEN_NONE;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/utf8_structural_validator.sv
// utf8_structural_validator: top level, input and result registers with handshake
// depends on utf8v_pkg and utf8v_step
//
// usage
// - input channel: i_in_valid / o_in_stall carry one stream byte per transaction
//   (i_data_byte) and a flag on the last byte of the stream (i_final_byte)
// - output channel: o_out_valid / i_out_stall carry one result per input byte:
//   status, error span, offending byte and o_stream_done on the closing result
// - a transaction completes at a rising edge with valid high and stall low
// - a byte taken waits in the input register, then moves to the result register
// - throughput: one byte per clock while the receiver does not stall, limited by
//   the single check stage between the input register and the result register
// - the first error of a stream is held and repeated until the final byte;
//   the stream after that starts again at position 0
// - reset (synchronous, active low) empties both registers and clears all
//   stream state; o_in_stall is low right after reset
// - when the receiver stalls, the result register holds; a byte already in the
//   input register waits there and o_in_stall rises until the result is taken
`default_nettype none

module utf8_structural_validator
    import utf8v_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // input channel
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [7:0]              i_data_byte,
    input  wire logic                    i_final_byte,
    // output channel
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [2:0]                   o_status,
    output logic [POS_OUT_BITS-1:0]      o_error_start,
    output logic [POS_OUT_BITS-1:0]      o_error_stop,
    output logic [7:0]                   o_error_value,
    output logic                         o_stream_done
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_final;

    // result register
    logic       r_out_valid;
    t_result    r_out;
    t_result    n_out;

    logic       in_take;
    logic       advance;

    // the check stage moves when the result register is empty or being drained
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte  <= i_data_byte;
            r_in_final <= i_final_byte;
        end
    end

    utf8v_step #(
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_data_byte  (r_in_byte),
        .i_final_byte (r_in_final),
        .o_result     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_error_start = r_out.error_start;
    assign o_error_stop  = r_out.error_stop;
    assign o_error_value = r_out.error_value;
    assign o_stream_done = r_out.stream_done;

`ifndef SYNTHESIS
    // clean results carry no error span or byte
    a_clean_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_OK || o_status == ST_VALID)
        |-> o_error_start == '0 && o_error_stop == '0 && o_error_value == '0)
        else $error("clean status with nonzero error fields");

    // valid-at-end and unexpected end only appear on the closing result
    a_end_status_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_VALID || o_status == ST_UNEXP_END)
        |-> o_stream_done)
        else $error("end-of-stream status without stream close");

    // a closing result never reports ok so far
    a_close_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stream_done |-> o_status != ST_OK)
        else $error("stream closed with ok-so-far status");

    // a byte parked in the input register moves on once the result is taken
    a_drain_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && o_out_valid && !i_out_stall |=> o_out_valid)
        else $error("pending byte did not reach the result register");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/utf8v_step.sv
// utf8v_step: stream state registers and the per-byte check logic
// depends on utf8v_pkg
`default_nettype none

module utf8v_step
    import utf8v_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_advance,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_final_byte,
    output t_result         o_result
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    logic [POSITION_BITS-1:0] r_byte_pos, n_byte_pos;
    logic [POSITION_BITS-1:0] r_lead_pos, n_lead_pos;
    logic [7:0]               r_lead_val, n_lead_val;
    logic [2:0]               r_seq_len, n_seq_len;
    logic [2:0]               r_collected, n_collected;
    logic [2:0]               r_bad_off, n_bad_off;
    logic [7:0]               r_bad_val, n_bad_val;
    t_status                  r_sticky, n_sticky;
    logic [POSITION_BITS-1:0] r_held_start, n_held_start;
    logic [POSITION_BITS-1:0] r_held_stop, n_held_stop;
    logic [7:0]               r_held_val, n_held_val;

    logic [POSITION_BITS-1:0] next_pos;
    logic [2:0]               collected_inc;
    logic                     cont_bad;
    logic [2:0]               bad_off;
    logic [7:0]               bad_val;
    logic [2:0]               lead_len;
    logic [POSITION_BITS:0]   sum_start;
    logic [POSITION_BITS:0]   sum_stop;
    logic [POSITION_BITS-1:0] sat_start;
    logic [POSITION_BITS-1:0] sat_stop;
    t_status                  status;
    logic [POSITION_BITS-1:0] es;
    logic [POSITION_BITS-1:0] et;
    logic [7:0]               ev;
    logic                     fresh;

    always_comb begin
        next_pos      = (r_byte_pos == POS_MAX) ? POS_MAX : r_byte_pos + 1'b1;
        collected_inc = r_collected + 3'd1;
        cont_bad      = (i_data_byte & CONT_MASK) != CONT_TAG;
        // offset of this byte in its sequence is the count before increment
        bad_off       = (cont_bad && r_bad_off == 3'd0) ? r_collected : r_bad_off;
        bad_val       = (cont_bad && r_bad_off == 3'd0) ? i_data_byte : r_bad_val;
        lead_len      = lead_length(i_data_byte);
        // saturating lead + offset and lead + offset + 1, side by side
        sum_start = {1'b0, r_lead_pos} + {{(POSITION_BITS-2){1'b0}}, bad_off};
        sum_stop  = {1'b0, r_lead_pos}
                  + {{(POSITION_BITS-2){1'b0}}, bad_off + 3'd1};
        sat_start = sum_start[POSITION_BITS] ? POS_MAX : sum_start[POSITION_BITS-1:0];
        sat_stop  = sum_stop[POSITION_BITS]  ? POS_MAX : sum_stop[POSITION_BITS-1:0];
    end

    always_comb begin
        status       = ST_OK;
        es           = '0;
        et           = '0;
        ev           = '0;
        fresh        = 1'b0;
        n_byte_pos   = next_pos;
        n_lead_pos   = r_lead_pos;
        n_lead_val   = r_lead_val;
        n_seq_len    = r_seq_len;
        n_collected  = r_collected;
        n_bad_off    = r_bad_off;
        n_bad_val    = r_bad_val;
        n_sticky     = r_sticky;
        n_held_start = r_held_start;
        n_held_stop  = r_held_stop;
        n_held_val   = r_held_val;

        if (r_sticky != ST_OK) begin
            status = r_sticky;
            es     = r_held_start;
            et     = r_held_stop;
            ev     = r_held_val;
        end else if (r_seq_len != 3'd0) begin
            n_collected = collected_inc;
            n_bad_off   = bad_off;
            n_bad_val   = bad_val;
            if (collected_inc >= r_seq_len) begin
                if (bad_off != 3'd0) begin
                    status = ST_BAD_CONT;
                    es     = sat_start;
                    et     = sat_stop;
                    ev     = bad_val;
                    fresh  = 1'b1;
                end
                n_seq_len   = 3'd0;
                n_collected = 3'd0;
                n_bad_off   = 3'd0;
                n_bad_val   = '0;
            end else if (i_final_byte) begin
                status = ST_UNEXP_END;
                es     = r_lead_pos;
                et     = next_pos;
                ev     = r_lead_val;
                fresh  = 1'b1;
            end
        end else if (i_data_byte[7]) begin
            if (lead_len == LEN_NONE) begin
                status = ST_BAD_START;
                es     = r_byte_pos;
                et     = next_pos;
                ev     = i_data_byte;
                fresh  = 1'b1;
            end else begin
                n_seq_len   = lead_len;
                n_collected = 3'd1;
                n_lead_pos  = r_byte_pos;
                n_lead_val  = i_data_byte;
                n_bad_off   = 3'd0;
                n_bad_val   = '0;
                if (i_final_byte) begin
                    status = ST_UNEXP_END;
                    es     = r_byte_pos;
                    et     = next_pos;
                    ev     = i_data_byte;
                    fresh  = 1'b1;
                end
            end
        end

        if (fresh) begin
            n_sticky     = status;
            n_held_start = es;
            n_held_stop  = et;
            n_held_val   = ev;
        end

        if (i_final_byte) begin
            if (status == ST_OK) begin
                status = ST_VALID;
            end
            n_byte_pos   = '0;
            n_lead_pos   = '0;
            n_lead_val   = '0;
            n_seq_len    = 3'd0;
            n_collected  = 3'd0;
            n_bad_off    = 3'd0;
            n_bad_val    = '0;
            n_sticky     = ST_OK;
            n_held_start = '0;
            n_held_stop  = '0;
            n_held_val   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos   <= '0;
            r_lead_pos   <= '0;
            r_lead_val   <= '0;
            r_seq_len    <= 3'd0;
            r_collected  <= 3'd0;
            r_bad_off    <= 3'd0;
            r_bad_val    <= '0;
            r_sticky     <= ST_OK;
            r_held_start <= '0;
            r_held_stop  <= '0;
            r_held_val   <= '0;
        end else if (i_advance) begin
            r_byte_pos   <= n_byte_pos;
            r_lead_pos   <= n_lead_pos;
            r_lead_val   <= n_lead_val;
            r_seq_len    <= n_seq_len;
            r_collected  <= n_collected;
            r_bad_off    <= n_bad_off;
            r_bad_val    <= n_bad_val;
            r_sticky     <= n_sticky;
            r_held_start <= n_held_start;
            r_held_stop  <= n_held_stop;
            r_held_val   <= n_held_val;
        end
    end

    // positions leave on a fixed-width field
    generate
        if (POSITION_BITS >= POS_OUT_BITS) begin : g_cut
            assign o_result.error_start = es[POS_OUT_BITS-1:0];
            assign o_result.error_stop  = et[POS_OUT_BITS-1:0];
        end else begin : g_ext
            assign o_result.error_start = {{(POS_OUT_BITS-POSITION_BITS){1'b0}}, es};
            assign o_result.error_stop  = {{(POS_OUT_BITS-POSITION_BITS){1'b0}}, et};
        end
    endgenerate

    assign o_result.status      = status;
    assign o_result.error_value = ev;
    assign o_result.stream_done = i_final_byte;

endmodule

`default_nettype wire

// File: verif/utf8_structural_validator_checker.sv
// utf8_structural_validator_checker: watches both channels, predicts each result and compares
// depends on utf8v_pkg for status codes, lead byte bounds and the result struct
`timescale 1ns / 100ps

module utf8_structural_validator_checker
    import utf8v_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    input  wire logic                    i_in_stall,
    input  wire logic [7:0]              i_data_byte,
    input  wire logic                    i_final_byte,
    input  wire logic                    i_out_valid,
    input  wire logic                    i_out_stall,
    input  wire logic [2:0]              i_status,
    input  wire logic [POS_OUT_BITS-1:0] i_error_start,
    input  wire logic [POS_OUT_BITS-1:0] i_error_stop,
    input  wire logic [7:0]              i_error_value,
    input  wire logic                    i_stream_done,
    output int                           o_fail_count,
    output int                           o_pending
);

    localparam logic [63:0] POS_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - POSITION_BITS);

    // stream state mirrored from the block
    logic [63:0] next_pos;
    logic [63:0] seq_lead_pos;
    logic [7:0]  seq_lead_byte;
    logic [2:0]  seq_len;
    logic [2:0]  seq_seen;
    logic [2:0]  bad_offset;
    logic [7:0]  bad_byte;
    t_status     held_status;
    logic [63:0] held_start;
    logic [63:0] held_stop;
    logic [7:0]  held_byte;

    t_result     awaited_status_q[$];

    function automatic logic [63:0] pos_add(input logic [63:0] a, input logic [63:0] b);
        if (a >= POS_LIMIT || b > POS_LIMIT - a) return POS_LIMIT;
        return a + b;
    endfunction

    task automatic clear_stream();
        next_pos      = '0;
        seq_lead_pos  = '0;
        seq_lead_byte = '0;
        seq_len       = LEN_NONE;
        seq_seen      = '0;
        bad_offset    = '0;
        bad_byte      = '0;
        held_status   = ST_OK;
        held_start    = '0;
        held_stop     = '0;
        held_byte     = '0;
    endtask

    // queue a predicted result behind those still awaited
    task automatic expect_result(input t_result r);
        awaited_status_q.insert(awaited_status_q.size(), r);
    endtask

    task automatic validate_byte(input logic [7:0] b, input logic fin, output t_result r);
        logic [63:0] pos;
        logic [63:0] pos_after;
        logic [63:0] es;
        logic [63:0] et;
        logic [7:0]  ev;
        t_status     st;
        logic [2:0]  len;
        logic        fresh;
        pos       = next_pos;
        pos_after = pos_add(pos, 64'd1);
        st        = ST_OK;
        es        = '0;
        et        = '0;
        ev        = '0;
        fresh     = 1'b0;
        if (held_status != ST_OK) begin
            st = held_status;
            es = held_start;
            et = held_stop;
            ev = held_byte;
        end else if (seq_len != LEN_NONE) begin
            seq_seen = seq_seen + 3'd1;
            if ((b & CONT_MASK) != CONT_TAG && bad_offset == 3'd0) begin
                bad_offset = seq_seen - 3'd1;
                bad_byte   = b;
            end
            if (seq_seen >= seq_len) begin
                if (bad_offset != 3'd0) begin
                    st    = ST_BAD_CONT;
                    es    = pos_add(seq_lead_pos, 64'(bad_offset));
                    et    = pos_add(es, 64'd1);
                    ev    = bad_byte;
                    fresh = 1'b1;
                end
                seq_len    = LEN_NONE;
                seq_seen   = '0;
                bad_offset = '0;
                bad_byte   = '0;
            end else if (fin) begin
                // truncation wins over a bad held continuation
                st    = ST_UNEXP_END;
                es    = seq_lead_pos;
                et    = pos_after;
                ev    = seq_lead_byte;
                fresh = 1'b1;
            end
        end else if (b >= CONT_TAG) begin
            if (b >= LEAD2_LO && b <= LEAD2_HI)      len = LEN_TWO;
            else if (b >= LEAD3_LO && b <= LEAD3_HI) len = LEN_THREE;
            else if (b >= LEAD4_LO && b <= LEAD4_HI) len = LEN_FOUR;
            else                                     len = LEN_NONE;
            if (len == LEN_NONE) begin
                st    = ST_BAD_START;
                es    = pos;
                et    = pos_after;
                ev    = b;
                fresh = 1'b1;
            end else begin
                seq_len       = len;
                seq_seen      = 3'd1;
                seq_lead_pos  = pos;
                seq_lead_byte = b;
                bad_offset    = '0;
                bad_byte      = '0;
                if (fin) begin
                    st    = ST_UNEXP_END;
                    es    = pos;
                    et    = pos_after;
                    ev    = b;
                    fresh = 1'b1;
                end
            end
        end
        if (fresh) begin
            held_status = st;
            held_start  = es;
            held_stop   = et;
            held_byte   = ev;
        end
        next_pos = pos_after;
        if (fin) begin
            if (st == ST_OK) st = ST_VALID;
            clear_stream();
        end
        r.status      = st;
        r.error_start = es[POS_OUT_BITS-1:0];
        r.error_stop  = et[POS_OUT_BITS-1:0];
        r.error_value = ev;
        r.stream_done = fin;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            o_fail_count = o_fail_count + 1;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        clear_stream();
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        t_result new_r;
        if (!i_rst_n) begin
            clear_stream();
            awaited_status_q.delete();
        end else begin
            // compare before predicting: a result never belongs to a byte taken at the same edge
            if (i_out_valid && !i_out_stall) begin
                if (awaited_status_q.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    $display("%0t: result with none expected, actual status %0h", $time,
                             i_status);
                end else begin
                    exp_r = awaited_status_q.pop_front();
                    check_field("status", 32'(exp_r.status), 32'(i_status));
                    check_field("error_start", exp_r.error_start, i_error_start);
                    check_field("error_stop", exp_r.error_stop, i_error_stop);
                    check_field("error_value", 32'(exp_r.error_value), 32'(i_error_value));
                    check_field("stream_done", 32'(exp_r.stream_done), 32'(i_stream_done));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                validate_byte(i_data_byte, i_final_byte, new_r);
                expect_result(new_r);
            end
        end
        o_pending = awaited_status_q.size();
    end

endmodule

// File: verif/utf8_structural_validator_tb.sv
// utf8_structural_validator_tb: stimulus and verdict for the utf-8 structural validator
// depends on utf8v_pkg, the validator rtl and utf8_structural_validator_checker
`timescale 1ns / 100ps

module utf8_structural_validator_tb;
    import utf8v_pkg::*;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [7:0]              i_data_byte;
    logic                    i_final_byte;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic [2:0]              o_status;
    logic [POS_OUT_BITS-1:0] o_error_start;
    logic [POS_OUT_BITS-1:0] o_error_stop;
    logic [7:0]              o_error_value;
    logic                    o_stream_done;

    int fail_count;
    int pending;

    // random idling on both channels; cleared for quiet stretches and the tail
    logic idle_on;
    int   stall_left;
    int   bytes_sent;

    // bytes of the stream being built, the last one goes out with the final flag
    logic [7:0] stream_bytes[$];

    utf8_structural_validator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_final_byte  (i_final_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_error_start (o_error_start),
        .o_error_stop  (o_error_stop),
        .o_error_value (o_error_value),
        .o_stream_done (o_stream_done)
    );

    utf8_structural_validator_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_data_byte   (i_data_byte),
        .i_final_byte  (i_final_byte),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_status      (o_status),
        .i_error_start (o_error_start),
        .i_error_stop  (o_error_stop),
        .i_error_value (o_error_value),
        .i_stream_done (o_stream_done),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // hard stop far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("FAIL utf8_structural_validator");
        $finish;
    end

    // receiver side: random stall bursts while idling is on
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 7);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // one input transaction; called and returning at a falling edge, so valid
    // gets a single assignment per time step and stays high back to back
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_final_byte <= fin;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent = bytes_sent + 1;
        @(negedge i_clk);
    endtask

    task automatic send_stream();
        for (int k = 0; k < stream_bytes.size(); k++)
            send_byte(stream_bytes[k], k == stream_bytes.size() - 1);
        stream_bytes.delete();
    endtask

    // hold the sender off until every outstanding result has been taken
    task automatic drain_results();
        i_in_valid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    // add one byte at the end of the stream being built
    task automatic append_byte(input logic [7:0] b);
        stream_bytes.insert(stream_bytes.size(), b);
    endtask

    function automatic logic [7:0] cont_byte();
        return CONT_TAG | 8'($urandom_range(0, 63));
    endfunction

    // one well-formed character: ascii or a full 2, 3 or 4 byte sequence
    task automatic add_char();
        int kind;
        kind = $urandom_range(0, 3);
        case (kind)
            0: begin
                append_byte(8'($urandom_range(0, 127)));
            end
            1: begin
                append_byte(8'($urandom_range(LEAD2_LO, LEAD2_HI)));
                append_byte(cont_byte());
            end
            2: begin
                append_byte(8'($urandom_range(LEAD3_LO, LEAD3_HI)));
                repeat (2) append_byte(cont_byte());
            end
            default: begin
                append_byte(8'($urandom_range(LEAD4_LO, LEAD4_HI)));
                repeat (3) append_byte(cont_byte());
            end
        endcase
    endtask

    // a broken stream: noise, a cut-off sequence, a bad continuation or a bad lead
    task automatic add_broken();
        int kind;
        int idx;
        int lead_at;
        logic [7:0] bad;
        kind = $urandom_range(0, 3);
        repeat ($urandom_range(0, 2)) add_char();
        case (kind)
            0: begin
                repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(0, 255)));
            end
            1: begin
                // lead near the end with too few continuations
                lead_at = stream_bytes.size();
                add_char();
                while (stream_bytes.size() - lead_at < 2) begin
                    stream_bytes.delete(lead_at);
                    add_char();
                end
                stream_bytes.delete(stream_bytes.size() - 1);
            end
            2: begin
                // a continuation replaced by a byte without the 10 tag
                lead_at = stream_bytes.size();
                add_char();
                while (stream_bytes.size() - lead_at < 2) begin
                    stream_bytes.delete(lead_at);
                    add_char();
                end
                idx = $urandom_range(lead_at + 1, stream_bytes.size() - 1);
                bad = $urandom_range(0, 1) ? 8'($urandom_range(0, 127))
                                           : 8'($urandom_range(8'hC0, 8'hFF));
                stream_bytes[idx] = bad;
                repeat ($urandom_range(0, 2)) add_char();
            end
            default: begin
                // stray continuation, overlong c0/c1 or a lead above f4
                bad = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hC1))
                                           : 8'($urandom_range(8'hF5, 8'hFF));
                append_byte(bad);
                repeat ($urandom_range(0, 2)) add_char();
            end
        endcase
    endtask

    initial begin
        int stream_idx;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_data_byte  = '0;
        i_final_byte = 1'b0;
        i_out_stall  = 1'b0;
        idle_on      = 1'b0;
        stall_left   = 0;
        bytes_sent   = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed streams, sent with no idling
        // ascii extremes
        send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b1);
        // shortest and longest legal sequences, edges of the lead ranges
        send_byte(8'hC2, 1'b0); send_byte(8'hBF, 1'b1);
        send_byte(8'hE0, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'hBF, 1'b1);
        send_byte(8'hF4, 1'b0); send_byte(8'h8F, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b1);
        // invalid start as the only byte
        send_byte(8'h80, 1'b1);
        // invalid start then a later byte that only repeats the held error
        send_byte(8'hFF, 1'b0); send_byte(8'h41, 1'b1);
        send_byte(8'hF5, 1'b1);
        // continuation without the 10 tag closing a two byte sequence
        send_byte(8'hDF, 1'b0); send_byte(8'h00, 1'b1);
        // stream ends on the lead itself
        send_byte(8'hE0, 1'b1);
        // stream cut short wins over a bad held continuation
        send_byte(8'hF0, 1'b0); send_byte(8'h41, 1'b0); send_byte(8'h80, 1'b1);
        // bad third byte of a three byte sequence, error sticks to the end
        send_byte(8'hEF, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hC0, 1'b0);
        send_byte(8'h41, 1'b1);

        drain_results();

        // random streams, mostly well formed; quiet stretches and a quiet tail
        stream_idx = 0;
        while (bytes_sent < 1225) begin
            idle_on = (stream_idx % 50 < 38) && (bytes_sent < 1050);
            if ($urandom_range(0, 99) < 80) begin
                repeat ($urandom_range(1, 6)) add_char();
            end else begin
                add_broken();
            end
            send_stream();
            if (stream_idx % 37 == 36) drain_results();
            stream_idx = stream_idx + 1;
        end
        idle_on = 1'b0;
        i_in_valid <= 1'b0;

        wait (pending == 0);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS utf8_structural_validator");
        end else begin
            $display("FAIL utf8_structural_validator");
        end
        $finish;
    end

endmodule
